// ----- src/pdg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the microcode program for the PCM decimator.
// Used by every module of the block; depends on nothing else.
package pdg_pkg;

  // Largest group size; larger register values are limited to it.
  localparam logic [4:0] MAX_DECIMATION = 5'd16;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_MAG    = 2'd1;
  localparam logic [1:0] REG_LEVEL  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [4:0] FACTOR_RST = 5'd2;
  localparam logic [7:0] MAG_RST    = 8'd16;
  localparam logic [7:0] LEVEL_RST  = 8'd0;

  // Output clamp limits.
  localparam logic signed [15:0] OUT_MAX = 16'sd32751;
  localparam logic signed [15:0] OUT_MIN = -16'sd32752;

  // Divider geometry: two quotient bits per cycle.
  localparam int DIV_W      = 42;
  localparam int AVG_W      = 22;
  localparam int STEP_W     = 5;
  localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(AVG_W / 2);
  localparam logic [STEP_W-1:0] GAIN_STEPS = STEP_W'(DIV_W / 2);

  // Micro-operations of the datapath.
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_ACCUM    = 4'd1,
    OP_DIV_AVG  = 4'd2,
    OP_AVG      = 4'd3,
    OP_DC       = 4'd4,
    OP_VAL      = 4'd5,
    OP_MUL_SM   = 4'd6,
    OP_ADD_SM   = 4'd7,
    OP_MUL_GAIN = 4'd8,
    OP_DIV_GAIN = 4'd9,
    OP_CLAMP    = 4'd10,
    OP_EMIT     = 4'd11
  } pdg_op_t;

  // Jump conditions; when true the step counter loads the target.
  typedef enum logic [2:0] {
    CND_NEVER      = 3'd0,
    CND_ALWAYS     = 3'd1,
    CND_GROUP_OPEN = 3'd2,
    CND_DIV_BUSY   = 3'd3,
    CND_SMOOTH_OFF = 3'd4,
    CND_OUT_FULL   = 3'd5
  } pdg_cond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    pdg_op_t         op;
    pdg_cond_t       cond;
    logic [PC_W-1:0] target;
  } pdg_uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic group_open;
    logic div_busy;
    logic smooth_off;
    logic out_full;
  } pdg_status_t;

  // Microcode program, one control word per step.
  function automatic pdg_uword_t pdg_rom(input logic [PC_W-1:0] pc);
    pdg_uword_t w;
    case (pc)
      4'd0:    w = '{OP_ACCUM,    CND_GROUP_OPEN, 4'd0};
      4'd1:    w = '{OP_DIV_AVG,  CND_NEVER,      4'd0};
      4'd2:    w = '{OP_NOP,      CND_DIV_BUSY,   4'd2};
      4'd3:    w = '{OP_AVG,      CND_NEVER,      4'd0};
      4'd4:    w = '{OP_DC,       CND_NEVER,      4'd0};
      4'd5:    w = '{OP_VAL,      CND_SMOOTH_OFF, 4'd8};
      4'd6:    w = '{OP_MUL_SM,   CND_NEVER,      4'd0};
      4'd7:    w = '{OP_ADD_SM,   CND_NEVER,      4'd0};
      4'd8:    w = '{OP_MUL_GAIN, CND_NEVER,      4'd0};
      4'd9:    w = '{OP_DIV_GAIN, CND_NEVER,      4'd0};
      4'd10:   w = '{OP_NOP,      CND_DIV_BUSY,   4'd10};
      4'd11:   w = '{OP_CLAMP,    CND_NEVER,      4'd0};
      4'd12:   w = '{OP_EMIT,     CND_OUT_FULL,   4'd12};
      4'd13:   w = '{OP_NOP,      CND_ALWAYS,     4'd0};
      default: w = '{OP_NOP,      CND_ALWAYS,     4'd0};
    endcase
    return w;
  endfunction

endpackage

// ----- src/pdg_div.sv -----
`timescale 1ns / 1ps
// Iterative unsigned divider by a small divisor, two quotient bits per cycle.
// Depends on pdg_pkg for the widths.
module pdg_div
  import pdg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [STEP_W-1:0]     steps,
  input  logic [4:0]            divisor,
  output logic                  busy,
  output logic [DIV_W-1:0]      quotient
);

  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [3:0]        rem_r, rem_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [4:0]        r1, r1s, r2, r2s;
  logic              ge1, ge2;

  // Two chained restoring steps on the narrow remainder.
  always_comb begin
    r1  = {rem_r, q_r[DIV_W-1]};
    ge1 = (r1 >= divisor);
    r1s = ge1 ? (r1 - divisor) : r1;
    r2  = {r1s[3:0], q_r[DIV_W-2]};
    ge2 = (r2 >= divisor);
    r2s = ge2 ? (r2 - divisor) : r2;
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt    = {q_r[DIV_W-3:0], ge1, ge2};
      rem_nxt  = r2s[3:0];
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ----- src/pdg_seq.sv -----
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on pdg_pkg for the control word and the program.
module pdg_seq
  import pdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pdg_status_t status,
  output pdg_op_t     op
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  pdg_uword_t      uw;
  logic            take;

  assign uw = pdg_rom(pc_r);
  assign op = uw.op;

  // Evaluate the jump condition of the current step.
  always_comb begin
    case (uw.cond)
      CND_NEVER:      take = 1'b0;
      CND_ALWAYS:     take = 1'b1;
      CND_GROUP_OPEN: take = status.group_open;
      CND_DIV_BUSY:   take = status.div_busy;
      CND_SMOOTH_OFF: take = status.smooth_off;
      CND_OUT_FULL:   take = status.out_full;
      default:        take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : (pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- src/pdg_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the PCM decimator: configuration, group sum, DC canceller,
// smoother, gain and output register. Depends on pdg_pkg and pdg_div.
module pdg_dp
  import pdg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pdg_op_t            op,
  output pdg_status_t        status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample
);

  // Configuration registers.
  logic [4:0] fac_r;
  logic [7:0] mag_r, lvl_r;
  logic [4:0] f_eff;

  // Working registers.
  logic signed [20:0] sum_r, sum_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic signed [21:0] avg_r, avg_nxt;
  logic signed [31:0] dc_r, dc_nxt;
  logic signed [32:0] v_r, v_nxt;
  logic signed [31:0] sv_r, sv_nxt;
  logic signed [42:0] m1_r, m1_nxt;
  logic signed [40:0] m2_r, m2_nxt;
  logic signed [41:0] prod_r, prod_nxt;
  logic signed [15:0] res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_r, out_nxt;

  // Intermediate values.
  logic               in_fire;
  logic [4:0]         cnt_inc;
  logic [21:0]        abs_sum, avg_dvd;
  logic signed [33:0] dc_t, dc_sh, dc_w;
  logic signed [32:0] dc_r8, dc_r8sh;
  logic [8:0]         lvl_inv;
  logic signed [43:0] sm_sum, sm_sh;
  logic [DIV_W-1:0]   gain_mag;
  logic [DIV_W-2:0]   q_half;
  logic               div_start, div_busy, out_full;
  logic [DIV_W-1:0]   div_dvd, div_quot;
  logic [STEP_W-1:0]  div_steps;

  // Register writes from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fac_r <= FACTOR_RST;
      mag_r <= MAG_RST;
      lvl_r <= LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FACTOR: fac_r <= cfg_wdata[4:0];
        REG_MAG:    mag_r <= cfg_wdata;
        REG_LEVEL:  lvl_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Effective group size: zero acts as one, large values are limited.
  always_comb begin
    if (fac_r == 5'd0) begin
      f_eff = 5'd1;
    end else if (fac_r > MAX_DECIMATION) begin
      f_eff = MAX_DECIMATION;
    end else begin
      f_eff = fac_r;
    end
  end

  // Input handshake and status toward the sequencer.
  assign in_stall  = (op != OP_ACCUM);
  assign in_fire   = in_valid && !in_stall;
  assign cnt_inc   = {1'b0, cnt_r} + 5'd1;
  assign out_full  = out_valid_r && out_stall;

  assign status.group_open = !in_fire || (cnt_inc < f_eff);
  assign status.div_busy   = div_busy;
  assign status.smooth_off = (lvl_r == 8'd0);
  assign status.out_full   = out_full;

  // Rounded group magnitude for the averaging divide.
  assign abs_sum = sum_r[20] ? (22'd0 - {1'b1, sum_r}) : {1'b0, sum_r};
  assign avg_dvd = abs_sum + {18'd0, f_eff[4:1]};

  // DC canceller arithmetic.
  assign dc_t  = {{8{avg_r[21]}}, avg_r, 4'b0000} + {{2{dc_r[31]}}, dc_r} + 34'sd16;
  assign dc_sh = dc_t >>> 5;
  assign dc_w  = {{2{dc_r[31]}}, dc_r} - dc_sh;
  assign dc_r8   = {dc_r[31], dc_r} + 33'sd8;
  assign dc_r8sh = dc_r8 >>> 4;

  // Smoother sum of the two registered products.
  assign lvl_inv = 9'd256 - {1'b0, lvl_r};
  assign sm_sum  = {m1_r[42], m1_r} + {{3{m2_r[40]}}, m2_r} + 44'sd128;
  assign sm_sh   = sm_sum >>> 8;

  // Gain magnitude and halved quotient.
  assign gain_mag = prod_r[41] ? (DIV_W'(0) - prod_r) : prod_r;
  assign q_half   = div_quot[DIV_W-1:1];

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = gain_mag;
    div_steps = GAIN_STEPS;
    case (op)
      OP_DIV_AVG: begin
        div_start = 1'b1;
        div_dvd   = {avg_dvd, {(DIV_W-AVG_W){1'b0}}};
        div_steps = AVG_STEPS;
      end
      OP_DIV_GAIN: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  pdg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .steps    (div_steps),
    .divisor  (f_eff),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Micro-operation decode.
  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    avg_nxt       = avg_r;
    dc_nxt        = dc_r;
    v_nxt         = v_r;
    sv_nxt        = sv_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (op)
      OP_ACCUM: begin
        if (in_fire) begin
          sum_nxt = sum_r + {{5{in_raw_sample[15]}}, in_raw_sample};
          cnt_nxt = cnt_inc[3:0];
        end
      end
      OP_DIV_AVG: begin
        neg_nxt = sum_r[20];
        sum_nxt = '0;
        cnt_nxt = '0;
      end
      OP_AVG: begin
        avg_nxt = neg_r ? (22'sd0 - $signed(div_quot[AVG_W-1:0]))
                        : $signed(div_quot[AVG_W-1:0]);
      end
      OP_DC: begin
        dc_nxt = dc_w[31:0];
      end
      OP_VAL: begin
        v_nxt = dc_r8sh + {{11{avg_r[21]}}, avg_r};
      end
      OP_MUL_SM: begin
        m1_nxt = v_r * $signed({1'b0, lvl_inv});
        m2_nxt = sv_r * $signed({1'b0, lvl_r});
      end
      OP_ADD_SM: begin
        sv_nxt = sm_sh[31:0];
        v_nxt  = {sm_sh[31], sm_sh[31:0]};
      end
      OP_MUL_GAIN: begin
        prod_nxt = v_r * $signed({1'b0, mag_r});
      end
      OP_DIV_GAIN: begin
        neg_nxt = prod_r[41];
      end
      OP_CLAMP: begin
        if (neg_r) begin
          res_nxt = (q_half > (DIV_W-1)'(32752)) ? OUT_MIN : (16'sd0 - $signed(q_half[15:0]));
        end else begin
          res_nxt = (q_half > (DIV_W-1)'(32751)) ? OUT_MAX : $signed(q_half[15:0]);
        end
      end
      OP_EMIT: begin
        if (!out_full) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      dc_r        <= '0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      dc_r        <= dc_nxt;
      sv_r        <= sv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r  <= neg_nxt;
    avg_r  <= avg_nxt;
    v_r    <= v_nxt;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_r;

endmodule

// ----- src/pcm_decimate_dc_block_gain.sv -----
`timescale 1ns / 1ps
// Top level of the decimating microphone front end with DC removal and gain.
// Depends on pdg_pkg, pdg_seq and pdg_dp.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid / in_stall   | in_raw_sample  (s16)
//   out     | output    | out_valid / out_stall | out_sample     (s16)
//   cfg     | input     | cfg_we                | cfg_index, cfg_wdata (u8)
//
// An item that does not close a group is taken without a stall. An item that
// closes a group stalls the input through the averaging divide, DC canceller,
// smoother (skipped when off), gain divide, clamp and emit steps, so no new
// item is taken until its result is emitted; a stalled output lengthens this.
// Most of the stall is spent in the shared two-bit-per-cycle divider, which
// runs 11 steps for the group average and 21 for the gain.
// Reset is synchronous and active low; it clears the step counter, the group
// sum and count, the DC tracker, the smoother state and the output valid
// flag, and loads the register defaults.
// A stalled output holds the sequencer in its emit step; input is stalled
// whenever the sequencer is not in its accumulate step.
module pcm_decimate_dc_block_gain
  import pdg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample
);

  pdg_op_t     op;
  pdg_status_t status;

  // Microcode sequencer.
  pdg_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  // Datapath with the divider and output register.
  pdg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pcm_decimate_dc_block_gain: a scoreboard class predicts each
// decimated, DC-blocked and scaled item, and random input gaps and output stalls stress the handshake.
// Depends on pdg_pkg and the RTL of the block.
module tb_top
  import pdg_pkg::*;
();

  localparam int LIMIT       = 300000;
  localparam int SETTLE      = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 40;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Predicts one result per completed group and checks results in order.
  class dc_gain_scoreboard;
    logic [4:0] factor_reg;
    logic [7:0] mag_reg;
    logic [7:0] level_reg;
    longint grp_sum;
    int unsigned grp_cnt;
    longint dc_trk;
    longint smooth_val;
    logic signed [15:0] expected_q[$];
    int n_in;
    int n_out;
    int n_err;

    function new();
      factor_reg = FACTOR_RST;
      mag_reg = MAG_RST;
      level_reg = LEVEL_RST;
      grp_sum = 0;
      grp_cnt = 0;
      dc_trk = 0;
      smooth_val = 0;
      n_in = 0;
      n_out = 0;
      n_err = 0;
    endfunction

    // Keeps the low 32 bits as a signed value.
    function longint wrap32(longint x);
      return longint'($signed(x[31:0]));
    endfunction

    // Mirrors a register write; values are masked to the register width.
    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_FACTOR: factor_reg = val[4:0];
        REG_MAG:    mag_reg = val;
        REG_LEVEL:  level_reg = val;
        default: ;
      endcase
    endfunction

    // Adds one accepted sample to the group and predicts the result it closes.
    function void note_sample(logic signed [15:0] raw);
      longint s, f, avg, v, lv, lm;
      s = raw;
      if (factor_reg == 0)
        f = 1;
      else if (factor_reg > MAX_DECIMATION)
        f = MAX_DECIMATION;
      else
        f = factor_reg;
      n_in++;
      grp_sum += s;
      grp_cnt++;
      if (grp_cnt < f)
        return;

      // Group average, rounded half away from zero.
      if (grp_sum >= 0)
        avg = (grp_sum + f / 2) / f;
      else
        avg = (grp_sum - f / 2) / f;
      grp_sum = 0;
      grp_cnt = 0;

      // DC canceller with the tracker held at -16 times the offset.
      dc_trk = wrap32(dc_trk - ((avg * 16 + dc_trk + 16) >>> 5));
      v = avg + ((dc_trk + 8) >>> 4);

      // Optional first-order smoother.
      if (level_reg != 0) begin
        lv = level_reg;
        v = wrap32((v * (256 - lv) + smooth_val * lv + 128) >>> 8);
        smooth_val = v;
      end

      // Gain stage and output clamp.
      lm = mag_reg;
      v = (v * lm) / (2 * f);
      if (v > OUT_MAX)
        v = OUT_MAX;
      if (v < OUT_MIN)
        v = OUT_MIN;
      expected_q.push_back(16'(v));
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      n_out++;
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected result %0d: got %0d", n_out, got);
        return;
      end
      want = expected_q.pop_front();
      if (want !== got) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch at result %0d: expected %0d, got %0d", n_out, want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_raw_sample;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_sample;

  dc_gain_scoreboard sb;
  bit idle_on;
  bit hold_req;
  int cycles;
  int n_cfg;

  pcm_decimate_dc_block_gain i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycles, sb.pending());
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result channel: random stall bursts, plus one long hold on request.
  initial begin : out_side
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req || (idle_on && $urandom_range(0, 7) == 0)) begin
        n = hold_req ? HOLD_CYCLES : $urandom_range(1, 16);
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_sample(out_sample);
  end

  // Offers one item and waits until the block takes it.
  task automatic send_sample(logic signed [15:0] x);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_raw_sample = 16'($urandom);
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_raw_sample = x;
    do @(posedge clk); while (in_stall);
    sb.note_sample(x);
  endtask

  // Stops offering items until all results are in and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register at the next falling edge.
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    n_cfg++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(logic [7:0] fw, logic [7:0] mw, logic [7:0] lw);
    wait_idle();
    write_reg(REG_FACTOR, fw);
    write_reg(REG_MAG, mw);
    write_reg(REG_LEVEL, lw);
  endtask

  // Mix of extremes, full-range noise, small values and a DC offset with noise.
  function automatic logic signed [15:0] pick_sample(int offset);
    int t;
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return 16'($urandom);
      4, 5: begin
        t = int'($urandom_range(0, 64)) - 32;
        return 16'(t);
      end
      default: begin
        t = offset + int'($urandom_range(0, 4095)) - 2048;
        if (t > 32767)
          t = 32767;
        if (t < -32768)
          t = -32768;
        return 16'(t);
      end
    endcase
  endfunction

  initial begin : stimulus
    int p, k, offset;
    logic [7:0] fw, mw, lw;
    sb = new();
    cycles = 0;
    n_cfg = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FACTOR;
    cfg_wdata = 8'd0;
    in_valid = 1'b0;
    in_raw_sample = 16'sd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: full-scale pairs and rounding of a negative half.
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd0);

    // Zero factor acts as one; largest gain drives the clamp.
    set_regs(8'h00, 8'd255, 8'd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);

    // Zero gain with the heaviest smoothing.
    set_regs(8'h02, 8'd0, 8'd255);
    send_sample(16'sd100);
    send_sample(-16'sd100);

    // Ignored register index, masked factor, lightest smoothing.
    wait_idle();
    write_reg(REG_UNUSED, 8'haa);
    set_regs(8'h41, 8'd1, 8'd1);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);

    // Factor lowered mid-group: the next item closes the group.
    set_regs(8'h04, 8'd16, 8'd0);
    send_sample(16'sd1000);
    send_sample(-16'sd3);
    send_sample(16'sd7);
    wait_idle();
    write_reg(REG_FACTOR, 8'h02);
    send_sample(16'sd20001);

    // Random phases with fresh settings; the last part runs without idling.
    for (p = 0; p < N_PHASES; p++) begin
      case ($urandom_range(0, 19))
        0, 1, 2:    fw = 8'd16;
        3, 4, 5:    fw = 8'($urandom_range(0, 255));
        default: fw = 8'($urandom_range(1, 4)) | 8'($urandom_range(0, 7) << 5);
      endcase
      mw = 8'($urandom_range(0, 255));
      lw = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      if (p == 0) begin
        fw = 8'h1f;
        mw = 8'd255;
        lw = 8'd255;
      end else if (p == 1) begin
        fw = 8'he0;
        mw = 8'd255;
        lw = 8'd0;
      end else if (p == 3) begin
        fw = 8'h01;
      end
      set_regs(fw, mw, lw);
      if (p >= N_PHASES - 2)
        idle_on = 1'b0;
      offset = int'($urandom_range(0, 40000)) - 20000;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Long output hold while items keep coming, so the block backs up.
        if (p == 3 && k == 5)
          hold_req = 1'b1;
        send_sample(pick_sample(offset));
      end
    end

    wait_idle();
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      sb.n_err++;
    end
    $display("summary: %0d samples in, %0d results checked, %0d register writes",
             sb.n_in, sb.n_out, n_cfg);
    $display("summary: factors 0 to 31, gain and smoothing extremes, %0d failures", sb.n_err);
    if (sb.n_err == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/pdg_pkg.sv
src/pdg_div.sv
src/pdg_seq.sv
src/pdg_dp.sv
src/pcm_decimate_dc_block_gain.sv
sim/tb_top.sv
